// File: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// check with active-low reset masking
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("imoc: check failed");

// check that holds in every cycle, reset included
`define ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("imoc: check failed");

`else

`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALL(lbl, clk, prop)

`endif

`endif

// File: design/imoc_pkg.sv
// types and constants of the imu offset calibration loop
`default_nettype none

package imoc_pkg;

    localparam int AXES       = 6;
    localparam int AXIS_ACC_Z = 2;

    localparam int WORD_W  = 16;
    localparam int QUOT_W  = 10;
    localparam int ERR_W   = 15;
    localparam int RANGE_W = 2;
    localparam int CIDX_W  = 2;

    // 1g level at the most sensitive range
    localparam logic [ERR_W-1:0] GRAVITY_BASE = 15'd16384;
    // bias added to negative values so the shift rounds toward zero
    localparam logic signed [WORD_W:0] DIV_ROUND = 17'sd63;
    localparam int DIV_SHIFT = 6;

    localparam logic [RANGE_W-1:0] RST_ACC_RANGE  = 2'd0;
    localparam logic [ERR_W-1:0]   RST_ERR_TARGET = 15'd8;
    localparam logic [WORD_W-1:0]  RST_ITER_LIMIT = 16'd100;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [QUOT_W-1:0] t_quot;
    typedef logic [ERR_W-1:0]         t_err;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ACC_RANGE  = 2'd0,
        CFG_ERR_TARGET = 2'd1,
        CFG_ITER_LIMIT = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_LOAD   = 1'b1
    } t_func;

    // what the merge stage found for one sample
    typedef struct packed {
        logic hit_target;
        logic hit_limit;
    } t_verdict;

endpackage

`default_nettype wire

// File: design/imoc_if.sv
// handshake interfaces: sample/load words, result words, register writes
`default_nettype none

interface imoc_in_if import imoc_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  func;
    t_word acc_x;
    t_word acc_y;
    t_word acc_z;
    t_word rate_x;
    t_word rate_y;
    t_word rate_z;

    modport source (
        output valid, func, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
        input  ready
    );
    modport sink (
        input  valid, func, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
        output ready
    );
endinterface

interface imoc_out_if import imoc_pkg::*; ();
    logic        valid;
    logic        ready;
    t_word       off_acc_x;
    t_word       off_acc_y;
    t_word       off_acc_z;
    t_word       off_rate_x;
    t_word       off_rate_y;
    t_word       off_rate_z;
    t_err        peak_error;
    logic [15:0] steps_done;
    logic        finished;
    logic        succeeded;

    modport source (
        output valid, off_acc_x, off_acc_y, off_acc_z, off_rate_x, off_rate_y,
               off_rate_z, peak_error, steps_done, finished, succeeded,
        input  ready
    );
    modport sink (
        input  valid, off_acc_x, off_acc_y, off_acc_z, off_rate_x, off_rate_y,
               off_rate_z, peak_error, steps_done, finished, succeeded,
        output ready
    );
endinterface

interface imoc_cfg_if import imoc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [WORD_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/imoc_lane.sv
// one axis lane: error, offset step (error / 64 toward zero) and saturated magnitude
`default_nettype none

module imoc_lane import imoc_pkg::*; (
    input  wire t_word             i_reading,
    input  wire logic [ERR_W-1:0]  i_bias,
    output t_quot                  o_quot,
    output t_err                   o_err
);

    logic signed [WORD_W:0] full;
    t_word                  wrapped;
    logic signed [WORD_W:0] rounded;
    logic [WORD_W:0]        mag;

    always_comb begin
        // full precision error
        full    = {i_reading[WORD_W-1], i_reading} - {2'b00, i_bias};
        // offset step uses the 16-bit wrapped error
        wrapped = full[WORD_W-1:0];
        rounded = {wrapped[WORD_W-1], wrapped} + (wrapped[WORD_W-1] ? DIV_ROUND : '0);
        o_quot  = rounded[DIV_SHIFT+QUOT_W-1:DIV_SHIFT];
        // magnitude saturates at the 15-bit ceiling
        mag     = full[WORD_W] ? (~full + 17'd1) : full;
        o_err   = (mag[WORD_W:ERR_W] != '0) ? '1 : mag[ERR_W-1:0];
    end

endmodule

`default_nettype wire

// File: design/imoc_merge.sv
// merge of the lane errors: peak magnitude and end-of-session verdict
`default_nettype none

module imoc_merge import imoc_pkg::*; (
    input  wire t_err              i_err [AXES],
    input  wire logic [ERR_W-1:0]  i_target,
    input  wire logic [WORD_W-1:0] i_limit,
    input  wire logic [WORD_W-1:0] i_step_next,
    output t_err                   o_peak,
    output t_verdict               o_verdict
);

    t_err m01;
    t_err m23;
    t_err m45;
    t_err m0123;

    always_comb begin
        m01    = (i_err[0] > i_err[1]) ? i_err[0] : i_err[1];
        m23    = (i_err[2] > i_err[3]) ? i_err[2] : i_err[3];
        m45    = (i_err[4] > i_err[5]) ? i_err[4] : i_err[5];
        m0123  = (m01 > m23) ? m01 : m23;
        o_peak = (m0123 > m45) ? m0123 : m45;

        o_verdict.hit_target = (o_peak < i_target);
        o_verdict.hit_limit  = (i_step_next >= i_limit);
    end

endmodule

`default_nettype wire

// File: design/imoc_offset_cal_top.sv
// top level of the imu offset calibration loop
`default_nettype none
`include "assert_macros.svh"

// an accepted word passes the stage 1 registers, then the output register, to its result word
// throughput: one word per cycle while the output side takes result words; the output register frees the input side
// stage 1: six axis lanes in parallel; stage 2: peak merge and session update
// the session state lives only in stage 2, so a word may follow in the next cycle
// reset (synchronous, active low): offsets zero, no session open, steps zero,
// acc range 0, error target 8, iteration limit 100, both pipeline stages empty

module imu_offset_calibration_loop_top import imoc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    imoc_in_if.sink    i_in,
    imoc_out_if.source o_out,
    imoc_cfg_if.sink   i_cfg
);

    // configuration registers
    logic [RANGE_W-1:0] r_acc_range;
    logic [ERR_W-1:0]   r_err_target;
    logic [WORD_W-1:0]  r_iter_limit;

    // session state
    t_word             r_off [AXES];
    logic [WORD_W-1:0] r_step;
    logic              r_over;
    logic              r_ok;

    t_word             n_off [AXES];
    logic [WORD_W-1:0] n_step;
    logic              n_over;
    logic              n_ok;
    t_err              n_peak;

    // stage 1 registers
    logic  r_s1_valid;
    logic  r_s1_func;
    t_word r_s1_raw  [AXES];
    t_quot r_s1_quot [AXES];
    t_err  r_s1_err  [AXES];

    // output register
    logic              r_out_valid;
    t_word             r_out_off [AXES];
    t_err              r_out_peak;
    logic [WORD_W-1:0] r_out_step;
    logic              r_out_over;
    logic              r_out_ok;

    logic              in_acc;
    logic              s1_go;
    logic [ERR_W-1:0]  gravity;
    logic [ERR_W-1:0]  bias [AXES];
    t_word             in_raw [AXES];
    t_quot             lane_quot [AXES];
    t_err              lane_err [AXES];
    t_err              peak;
    t_verdict          verdict;
    logic [WORD_W-1:0] step_next;

    // handshake: stage 1 drains into the output register whenever it is free
    assign s1_go      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // 1g level for the z accelerometer lane
    assign gravity = GRAVITY_BASE >> r_acc_range;

    assign in_raw[0] = i_in.acc_x;
    assign in_raw[1] = i_in.acc_y;
    assign in_raw[2] = i_in.acc_z;
    assign in_raw[3] = i_in.rate_x;
    assign in_raw[4] = i_in.rate_y;
    assign in_raw[5] = i_in.rate_z;

    // one lane per axis, only the z accelerometer carries the 1g bias
    for (genvar k = 0; k < AXES; k++) begin : g_lane
        assign bias[k] = (k == AXIS_ACC_Z) ? gravity : '0;

        imoc_lane u_lane (
            .i_reading (in_raw[k]),
            .i_bias    (bias[k]),
            .o_quot    (lane_quot[k]),
            .o_err     (lane_err[k])
        );
    end

    assign step_next = r_step + 16'd1;

    imoc_merge u_merge (
        .i_err       (r_s1_err),
        .i_target    (r_err_target),
        .i_limit     (r_iter_limit),
        .i_step_next (step_next),
        .o_peak      (peak),
        .o_verdict   (verdict)
    );

    // session update for the word leaving stage 1
    always_comb begin
        n_off  = r_off;
        n_step = r_step;
        n_over = r_over;
        n_ok   = r_ok;
        n_peak = '0;
        if (t_func'(r_s1_func) == FUNC_LOAD) begin
            n_off  = r_s1_raw;
            n_step = '0;
            n_ok   = 1'b0;
            // a zero limit closes the session straight away with failure
            n_over = (r_iter_limit == '0);
        end else if (!r_over) begin
            for (int k = 0; k < AXES; k++) begin
                n_off[k] = r_off[k] - {{(WORD_W-QUOT_W){r_s1_quot[k][QUOT_W-1]}},
                                       r_s1_quot[k]};
            end
            n_step = step_next;
            n_peak = peak;
            // success wins over the limit on the same step
            priority if (verdict.hit_target) begin
                n_over = 1'b1;
                n_ok   = 1'b1;
            end else if (verdict.hit_limit) begin
                n_over = 1'b1;
                n_ok   = 1'b0;
            end else begin
                // session stays open
                n_over = r_over;
                n_ok   = r_ok;
            end
        end
    end

    // control, configuration and session state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_range  <= RST_ACC_RANGE;
            r_err_target <= RST_ERR_TARGET;
            r_iter_limit <= RST_ITER_LIMIT;
            r_off        <= '{default: '0};
            r_step       <= '0;
            r_over       <= 1'b1;
            r_ok         <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_ACC_RANGE:  r_acc_range  <= i_cfg.data[RANGE_W-1:0];
                    CFG_ERR_TARGET: r_err_target <= i_cfg.data[ERR_W-1:0];
                    CFG_ITER_LIMIT: r_iter_limit <= i_cfg.data;
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go) begin
                r_out_valid <= 1'b1;
                r_off       <= n_off;
                r_step      <= n_step;
                r_over      <= n_over;
                r_ok        <= n_ok;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func <= i_in.func;
            r_s1_raw  <= in_raw;
            r_s1_quot <= lane_quot;
            r_s1_err  <= lane_err;
        end
        if (s1_go) begin
            r_out_off  <= n_off;
            r_out_peak <= n_peak;
            r_out_step <= n_step;
            r_out_over <= n_over;
            r_out_ok   <= n_ok;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.off_acc_x  = r_out_off[0];
    assign o_out.off_acc_y  = r_out_off[1];
    assign o_out.off_acc_z  = r_out_off[2];
    assign o_out.off_rate_x = r_out_off[3];
    assign o_out.off_rate_y = r_out_off[4];
    assign o_out.off_rate_z = r_out_off[5];
    assign o_out.peak_error = r_out_peak;
    assign o_out.steps_done = r_out_step;
    assign o_out.finished   = r_out_over;
    assign o_out.succeeded  = r_out_ok;

    // a session can only succeed once it has ended
    `ASSERT_RST(a_ok_needs_over, i_clk, i_rst_n, r_ok |-> r_over)
    // a word held in stage 1 is never dropped
    `ASSERT_RST(a_s1_kept, i_clk, i_rst_n, (r_s1_valid && !s1_go) |=> r_s1_valid)
    // a load with a nonzero limit opens a fresh session
    `ASSERT_RST(a_load_opens, i_clk, i_rst_n,
                (s1_go && r_s1_func && (r_iter_limit != '0)) |=> (!r_over && (r_step == '0)))
    // the result word reports success only for an ended session
    `ASSERT_RST(a_out_ok_over, i_clk, i_rst_n, r_out_valid |-> (!r_out_ok || r_out_over))

endmodule

`default_nettype wire
